@@ design/spce_pkg.sv @@
// Package for the successor path cost evaluator.
// Field widths, command codes, result selects and the control/status structs
// shared by the controller, the datapath and the channel interfaces.
package spce_pkg;

  localparam int CMD_W  = 3;
  localparam int VTX_W  = 6;
  localparam int COST_W = 16;
  localparam int TIME_W = 17;
  localparam int TOT_W  = 23;
  localparam int ACC_W  = 22;
  localparam int VCFG_W = 7;

  localparam logic [VCFG_W-1:0] VCOUNT_RESET = 7'd64;
  localparam logic [ACC_W-1:0]  ACC_MAX      = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_SELECT = 3'd2,
    CMD_QUERY  = 3'd3,
    CMD_EVAL   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_SELECT,
    RES_QUERY,
    RES_PATH_OK,
    RES_PATH_BAD
  } res_sel_e;

  // controller -> datapath
  typedef struct packed {
    logic     load;          // latch the input item
    logic     clr_succ;      // drop every successor
    logic     edge_we;       // write edge at (origin, dest)
    logic     edge_re_fld;   // read edge at (origin, dest)
    logic     succ_re_fld;   // read successor of origin
    logic     succ_we;       // origin -> dest
    logic     walk_init;
    logic     succ_re_walk;  // read successor of current position
    logic     edge_re_walk;  // read edge (position, successor just read)
    logic     walk_step;     // accumulate edge, advance, read next successor
    logic     res_load;
    res_sel_e res_sel;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    cmd_e cmd;
    logic in_range;
    logic edge_absent;
    logic succ_dead;
    logic at_target;
    logic steps_last;
  } status_t;

endpackage

@@ design/spce_item_if.sv @@
// Input channel of the successor path cost evaluator: valid/ready plus one
// command item. Depends on spce_pkg for the field widths.
interface spce_item_if import spce_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [VTX_W-1:0]         origin_vertex;
  logic [VTX_W-1:0]         dest_vertex;
  logic [COST_W-1:0]        edge_cost;
  logic signed [TIME_W-1:0] edge_time;

  modport source (output valid, cmd, origin_vertex, dest_vertex, edge_cost, edge_time,
                  input ready);
  modport sink   (input valid, cmd, origin_vertex, dest_vertex, edge_cost, edge_time,
                  output ready);
endinterface

@@ design/spce_result_if.sv @@
// Result channel of the successor path cost evaluator: valid/ready plus one
// result item. Depends on spce_pkg for the field widths.
interface spce_result_if import spce_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    status;
  logic                    is_chosen;
  logic                    path_valid;
  logic signed [TOT_W-1:0] path_cost;
  logic signed [TOT_W-1:0] path_time;

  modport source (output valid, status, is_chosen, path_valid, path_cost, path_time,
                  input ready);
  modport sink   (input valid, status, is_chosen, path_valid, path_cost, path_time,
                  output ready);
endinterface

@@ design/spce_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. No dependencies.
module spce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/spce_ctrl.sv @@
// Controller of the successor path cost evaluator: sequences each command and
// the path walk, owns the channel handshakes. Depends on spce_pkg.
module spce_ctrl import spce_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEL_RD,
    S_QRY_RD,
    S_WALK_SUCC,
    S_WALK_NEXT,
    S_WALK_EDGE,
    S_FINISH
  } state_e;

  state_e   state_q, state_d;
  res_sel_e res_sel_q, res_sel_d;
  logic     out_valid_q, out_valid_d;
  logic     slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    res_sel_d   = res_sel_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ctrl_o      = '0;
    ctrl_o.res_sel = res_sel_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status_i.cmd)
          CMD_CLEAR: begin
            ctrl_o.clr_succ = 1'b1;
            res_sel_d       = RES_ZERO;
            state_d         = S_FINISH;
          end
          CMD_WRITE: begin
            ctrl_o.edge_we = status_i.in_range;
            res_sel_d      = RES_ZERO;
            state_d        = S_FINISH;
          end
          CMD_SELECT: begin
            ctrl_o.edge_re_fld = 1'b1;
            state_d            = S_SEL_RD;
          end
          CMD_QUERY: begin
            ctrl_o.succ_re_fld = 1'b1;
            state_d            = S_QRY_RD;
          end
          CMD_EVAL: begin
            ctrl_o.walk_init = 1'b1;
            state_d          = S_WALK_SUCC;
          end
          default: begin
            res_sel_d = RES_ZERO;
            state_d   = S_FINISH;
          end
        endcase
      end
      S_SEL_RD: begin
        ctrl_o.succ_we = status_i.in_range && !status_i.edge_absent;
        res_sel_d      = RES_SELECT;
        state_d        = S_FINISH;
      end
      S_QRY_RD: begin
        res_sel_d = RES_QUERY;
        state_d   = S_FINISH;
      end
      S_WALK_SUCC: begin
        ctrl_o.succ_re_walk = 1'b1;
        state_d             = S_WALK_NEXT;
      end
      S_WALK_NEXT: begin
        if (status_i.succ_dead) begin
          res_sel_d = RES_PATH_BAD;
          state_d   = S_FINISH;
        end else begin
          ctrl_o.edge_re_walk = 1'b1;
          state_d             = S_WALK_EDGE;
        end
      end
      S_WALK_EDGE: begin
        if (status_i.edge_absent) begin
          res_sel_d = RES_PATH_BAD;
          state_d   = S_FINISH;
        end else begin
          ctrl_o.walk_step = 1'b1;
          if (status_i.at_target) begin
            res_sel_d = RES_PATH_OK;
            state_d   = S_FINISH;
          end else if (status_i.steps_last) begin
            res_sel_d = RES_PATH_BAD;
            state_d   = S_FINISH;
          end else begin
            state_d = S_WALK_NEXT;  // next successor read issued by the step
          end
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          ctrl_o.res_load = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_sel_q   <= RES_ZERO;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_sel_q   <= res_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ design/spce_datapath.sv @@
// Datapath of the successor path cost evaluator: vertex count register, edge
// store and successor table RAMs, walk registers and the result register.
// Depends on spce_pkg and spce_ram.
module spce_datapath import spce_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [VCFG_W-1:0]        cfg_wdata_i,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic [VTX_W-1:0]         origin_i,
  input  logic [VTX_W-1:0]         dest_i,
  input  logic [COST_W-1:0]        cost_i,
  input  logic [TIME_W-1:0]        time_i,
  input  ctrl_t                    ctrl_i,
  output status_t                  status_o,
  output logic                     status_bit_o,
  output logic                     is_chosen_o,
  output logic                     path_valid_o,
  output logic [TOT_W-1:0]         path_cost_o,
  output logic [TOT_W-1:0]         path_time_o
);

  localparam int VW     = $clog2(MAX_VERTICES);
  localparam int CW     = ($clog2(MAX_VERTICES + 1) > VCFG_W) ?
                          $clog2(MAX_VERTICES + 1) : VCFG_W;
  localparam int EW     = 2 * WEIGHT_BITS + 1;
  localparam int EDEPTH = MAX_VERTICES << VW;
  localparam logic [32:0] WMAX = (33'd1 << WEIGHT_BITS) - 33'd1;
  localparam int SW     = ((ACC_W > WEIGHT_BITS) ? ACC_W : WEIGHT_BITS) + 1;

  logic [VCFG_W-1:0]      vcount_q;
  logic [CW-1:0]          vc;

  logic [CMD_W-1:0]       cmd_q;
  logic [VW-1:0]          org_q, dst_q;
  logic                   in_range_q;
  logic [COST_W-1:0]      cost_q;
  logic [TIME_W-1:0]      time_q;

  logic [VW-1:0]          pos_q, nx_q;
  logic [CW-1:0]          steps_q;
  logic [ACC_W-1:0]       cost_acc_q, time_acc_q;

  logic [MAX_VERTICES-1:0] succ_vld_q;
  logic                    succ_vld_rd_q;

  logic [EW-1:0]          edge_wdata, edge_rd;
  logic [2*VW-1:0]        edge_raddr;
  logic                   edge_re;
  logic [VW-1:0]          succ_raddr, succ_rd;
  logic                   succ_re;

  logic [WEIGHT_BITS-1:0] cost_sat, time_sat;
  logic [WEIGHT_BITS-1:0] e_cost, e_time;
  logic [SW-1:0]          cost_sum, time_sum;

  logic                   res_status_q, res_chosen_q, res_valid_q;
  logic [TOT_W-1:0]       res_cost_q, res_time_q;
  logic                   res_status_d, res_chosen_d, res_valid_d;
  logic [TOT_W-1:0]       res_cost_d, res_time_d;

  // effective vertex count, saturated to 2..MAX_VERTICES
  always_comb begin
    vc = CW'(vcount_q);
    if (vc < CW'(2)) begin
      vc = CW'(2);
    end else if (vc > CW'(MAX_VERTICES)) begin
      vc = CW'(MAX_VERTICES);
    end
  end

  // edge entry: {absent, time, cost}; negative time marks the edge absent
  assign cost_sat = (33'(cost_q) > WMAX) ? WEIGHT_BITS'(WMAX) : WEIGHT_BITS'(cost_q);
  assign time_sat = (33'(time_q[TIME_W-2:0]) > WMAX) ?
                    WEIGHT_BITS'(WMAX) : WEIGHT_BITS'(time_q[TIME_W-2:0]);
  assign edge_wdata = time_q[TIME_W-1] ? {1'b1, {WEIGHT_BITS{1'b0}}, cost_sat}
                                       : {1'b0, time_sat, cost_sat};

  assign edge_re    = ctrl_i.edge_re_fld || ctrl_i.edge_re_walk;
  assign edge_raddr = ctrl_i.edge_re_fld ? {org_q, dst_q} : {pos_q, succ_rd};

  spce_ram #(.WIDTH(EW), .DEPTH(EDEPTH)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.edge_we),
    .waddr_i ({org_q, dst_q}),
    .wdata_i (edge_wdata),
    .re_i    (edge_re),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rd)
  );

  assign succ_re    = ctrl_i.succ_re_fld || ctrl_i.succ_re_walk || ctrl_i.walk_step;
  assign succ_raddr = ctrl_i.succ_re_fld ? org_q : (ctrl_i.walk_step ? nx_q : pos_q);

  spce_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_succ_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.succ_we),
    .waddr_i (org_q),
    .wdata_i (dst_q),
    .re_i    (succ_re),
    .raddr_i (succ_raddr),
    .rdata_o (succ_rd)
  );

  assign e_cost   = edge_rd[WEIGHT_BITS-1:0];
  assign e_time   = edge_rd[2*WEIGHT_BITS-1:WEIGHT_BITS];
  assign cost_sum = SW'(cost_acc_q) + SW'(e_cost);
  assign time_sum = SW'(time_acc_q) + SW'(e_time);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q      <= VCOUNT_RESET;
      succ_vld_q    <= '0;
      succ_vld_rd_q <= 1'b0;
      pos_q         <= '0;
      steps_q       <= '0;
      cost_acc_q    <= '0;
      time_acc_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      if (ctrl_i.clr_succ) begin
        succ_vld_q <= '0;
      end else if (ctrl_i.succ_we) begin
        succ_vld_q[org_q] <= 1'b1;
      end
      if (succ_re) begin
        succ_vld_rd_q <= succ_vld_q[succ_raddr];
      end
      if (ctrl_i.walk_init) begin
        pos_q      <= '0;
        steps_q    <= '0;
        cost_acc_q <= '0;
        time_acc_q <= '0;
      end else if (ctrl_i.walk_step) begin
        pos_q      <= nx_q;
        steps_q    <= steps_q + CW'(1);
        cost_acc_q <= (cost_sum > SW'(ACC_MAX)) ? ACC_MAX : ACC_W'(cost_sum);
        time_acc_q <= (time_sum > SW'(ACC_MAX)) ? ACC_MAX : ACC_W'(time_sum);
      end
    end
  end

  // item fields and walk payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q      <= cmd_i;
      org_q      <= VW'(origin_i);
      dst_q      <= VW'(dest_i);
      in_range_q <= (CW'(origin_i) < vc) && (CW'(dest_i) < vc);
      cost_q     <= cost_i;
      time_q     <= time_i;
    end
    if (ctrl_i.edge_re_walk) begin
      nx_q <= succ_rd;
    end
  end

  assign status_o.cmd         = cmd_e'(cmd_q);
  assign status_o.in_range    = in_range_q;
  assign status_o.edge_absent = edge_rd[EW-1];
  assign status_o.succ_dead   = !succ_vld_rd_q || (CW'(succ_rd) >= vc);
  assign status_o.at_target   = (CW'(nx_q) == vc - CW'(1));
  assign status_o.steps_last  = ((steps_q + CW'(1)) == vc);

  // result fields; those that do not belong to the command stay zero
  always_comb begin
    res_status_d = 1'b0;
    res_chosen_d = 1'b0;
    res_valid_d  = 1'b0;
    res_cost_d   = '0;
    res_time_d   = '0;
    case (ctrl_i.res_sel)
      RES_SELECT: begin
        res_status_d = !in_range_q || edge_rd[EW-1];
      end
      RES_QUERY: begin
        res_chosen_d = in_range_q && succ_vld_rd_q && (succ_rd == dst_q);
      end
      RES_PATH_OK: begin
        res_valid_d = 1'b1;
        res_cost_d  = {1'b0, cost_acc_q};
        res_time_d  = {1'b0, time_acc_q};
      end
      RES_PATH_BAD: begin
        res_cost_d = '1;
        res_time_d = '1;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.res_load) begin
      res_status_q <= res_status_d;
      res_chosen_q <= res_chosen_d;
      res_valid_q  <= res_valid_d;
      res_cost_q   <= res_cost_d;
      res_time_q   <= res_time_d;
    end
  end

  assign status_bit_o = res_status_q;
  assign is_chosen_o  = res_chosen_q;
  assign path_valid_o = res_valid_q;
  assign path_cost_o  = res_cost_q;
  assign path_time_o  = res_time_q;

endmodule

@@ design/successor_path_cost_evaluator_top.sv @@
// Successor path cost evaluator, top level.
// Ties the controller and datapath to the item and result channels.
// Depends on spce_pkg, spce_item_if, spce_result_if, spce_ctrl, spce_datapath.
//
// Usage:
//   item_i   : one command per item (clear successors, write edge, select
//              edge, query selection, evaluate path). Valid/ready handshake.
//   result_o : exactly one result item per command, valid/ready handshake.
//   cfg_we_i / cfg_wdata_i : vertex limit register; the user must write it
//              only while idle, the block itself does not enforce it.
// Flow: one item in flight. Clear, write and unknown commands go from decode
//   to the result; select and query add a registered RAM read. Evaluate
//   reads one successor and one edge per step until it meets the target, a
//   dead successor, an absent edge or as many steps as there are vertices.
//   A new item is accepted the cycle after the previous result is registered.
// Reset: successor table reads as empty (valid bits cleared), the vertex
//   limit is 64, edge store contents are undefined until written.
// Stall: the result stays in the output register while the receiver is not
//   ready; the next item is still accepted and worked on, and waits to
//   register its result until the output register frees.
module successor_path_cost_evaluator_top import spce_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [VCFG_W-1:0] cfg_wdata_i,
  spce_item_if.sink         item_i,
  spce_result_if.source     result_o
);

  ctrl_t   ctrl;
  status_t status;

  spce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  spce_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (item_i.cmd),
    .origin_i     (item_i.origin_vertex),
    .dest_i       (item_i.dest_vertex),
    .cost_i       (item_i.edge_cost),
    .time_i       (item_i.edge_time),
    .ctrl_i       (ctrl),
    .status_o     (status),
    .status_bit_o (result_o.status),
    .is_chosen_o  (result_o.is_chosen),
    .path_valid_o (result_o.path_valid),
    .path_cost_o  (result_o.path_cost),
    .path_time_o  (result_o.path_time)
  );

endmodule
